/* rtl/fvud_pkg.sv */
// types, constants and the hex digit function for the form value url decoder
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package fvud_pkg;

    // decoder phases
    typedef enum logic [2:0] {
        PH_KEY   = 3'd0,
        PH_VALUE = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_DRAIN = 3'd4
    } t_phase;

    // delimiter characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_PCT = 8'h25;

    // code returned for a byte that is not a hex digit (minus one)
    localparam logic [7:0] HEX_BAD = 8'hFF;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } t_result;

    // what one byte does to the decoder
    typedef struct packed {
        logic       res_vld;
        t_result    res;
        t_phase     next_phase;
        logic       hd_we;
        logic [4:0] next_hd;
    } t_step;

    // hex digit value in 8-bit two's complement, minus one when invalid
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end
        return v;
    endfunction

endpackage

/* rtl/fvud_step.sv */
// next phase and result for one input byte, purely combinational
// depends on fvud_pkg
`timescale 1ns / 1ps

module fvud_step import fvud_pkg::*; (
    input  t_phase     i_phase,
    input  logic [4:0] i_high_digit,
    input  logic [7:0] i_byte,
    output t_step      o_step
);

    logic [7:0] w_hex;
    logic [7:0] w_pair;
    logic       w_nul;

    assign w_hex  = hex_value(i_byte);
    // high digit times sixteen, modulo 256, plus the low digit
    assign w_pair = {i_high_digit[3:0], 4'b0000} + w_hex;
    assign w_nul  = (i_byte == CH_NUL);

    // phase machine decision
    always_comb begin
        o_step            = '0;
        o_step.next_phase = i_phase;
        o_step.next_hd    = w_hex[4:0];
        case (i_phase)
            PH_DRAIN: begin
                if (w_nul) o_step.next_phase = PH_KEY;
            end
            PH_HEX1: begin
                if (w_nul) begin
                    o_step.next_phase   = PH_KEY;
                    o_step.res_vld      = 1'b1;
                    o_step.res.last     = 1'b1;
                end else begin
                    o_step.hd_we        = 1'b1;
                    o_step.next_phase   = PH_HEX2;
                end
            end
            PH_HEX2: begin
                o_step.res_vld = 1'b1;
                if (w_nul) begin
                    o_step.next_phase   = PH_KEY;
                    o_step.res.last     = 1'b1;
                end else begin
                    o_step.next_phase   = PH_VALUE;
                    o_step.res.out_byte = w_pair;
                    o_step.res.has_byte = 1'b1;
                end
            end
            PH_VALUE: begin
                if (w_nul) begin
                    o_step.next_phase   = PH_KEY;
                    o_step.res_vld      = 1'b1;
                    o_step.res.last     = 1'b1;
                end else if (i_byte == CH_AMP) begin
                    o_step.next_phase   = PH_DRAIN;
                    o_step.res_vld      = 1'b1;
                    o_step.res.last     = 1'b1;
                end else if (i_byte == CH_PCT) begin
                    o_step.next_phase   = PH_HEX1;
                end else if (i_byte != CH_EQ) begin
                    o_step.res_vld      = 1'b1;
                    o_step.res.out_byte = i_byte;
                    o_step.res.has_byte = 1'b1;
                end
            end
            default: begin
                // key bytes, and any code that cannot be reached
                o_step.next_phase = PH_KEY;
                if (w_nul) begin
                    o_step.res_vld    = 1'b1;
                    o_step.res.last   = 1'b1;
                end else if (i_byte == CH_AMP) begin
                    o_step.next_phase = PH_DRAIN;
                    o_step.res_vld    = 1'b1;
                    o_step.res.last   = 1'b1;
                end else if (i_byte == CH_EQ) begin
                    o_step.next_phase = PH_VALUE;
                end
            end
        endcase
    end

endmodule

/* rtl/fvud_out_buf.sv */
// result register with a skid stage behind it
// depends on fvud_pkg
`timescale 1ns / 1ps

module fvud_out_buf import fvud_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_res,
    output logic    o_room,
    output logic    o_vld,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    w_load;

    // output register free for new data this cycle
    assign w_load = !r_out_vld || i_ready;
    assign o_room = !r_skid_vld;
    assign o_vld  = r_out_vld;
    assign o_res  = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= r_skid_vld && i_push;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
                if (i_push) r_skid <= i_push_res;
            end else if (i_push) begin
                r_out <= i_push_res;
            end
        end else if (i_push) begin
            r_skid <= i_push_res;
        end
    end

endmodule

/* rtl/form_value_url_decoder_unit.sv */
// form value url decoder: one byte in per cycle while s_axis_tready is high, decoded first-field value out
// a result is registered in the output register, or in the skid stage while the master side stalls
// throughput: one byte per cycle while the slave side is ready, set by the registered phase update
// the skid stage keeps the slave side open while one result waits
// reset: phase back to skipping key bytes, high digit zero, result stages empty
// top level; depends on fvud_pkg, fvud_step and fvud_out_buf
`timescale 1ns / 1ps

module form_value_url_decoder_unit import fvud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] has_byte
    output logic       m_axis_tlast
);

    t_phase     r_phase;
    logic [4:0] r_high_digit;
    t_step      w_step;
    t_result    w_out;
    logic       w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    fvud_step u_step (
        .i_phase      (r_phase),
        .i_high_digit (r_high_digit),
        .i_byte       (s_axis_tdata),
        .o_step       (w_step)
    );

    // decoder state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_KEY;
            r_high_digit <= 5'd0;
        end else if (w_accept) begin
            r_phase <= w_step.next_phase;
            if (w_step.hd_we) r_high_digit <= w_step.next_hd;
        end
    end

    fvud_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept && w_step.res_vld),
        .i_push_res (w_step.res),
        .o_room     (s_axis_tready),
        .o_vld      (m_axis_tvalid),
        .o_res      (w_out),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = w_out.out_byte;
    assign m_axis_tuser = w_out.has_byte;
    assign m_axis_tlast = w_out.last;

    // field end never carries a character
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && (m_axis_tdata == 8'h00))
        else $error("last result carries data");

    // a zero byte always rearms the decoder
    a_nul_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (s_axis_tdata == CH_NUL) |=> r_phase == PH_KEY)
        else $error("zero byte did not rearm");

    // a percent in the value always opens an escape
    a_pct_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (r_phase == PH_VALUE) && (s_axis_tdata == CH_PCT)
        |=> r_phase == PH_HEX1)
        else $error("percent did not open escape");

    // slave side closes only while a result is stalled on the master side
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled without pending result");

endmodule
